/* hdl/paired_frame_slot_manager_defines.svh */
// ---------------------------------------------------------------------------
// paired frame slot manager assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef PAIRED_FRAME_SLOT_MANAGER_DEFINES_SVH
`define PAIRED_FRAME_SLOT_MANAGER_DEFINES_SVH

// same-cycle implication
`define PFSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfsm_pkg.sv */
// ---------------------------------------------------------------------------
// pfsm_pkg
// shared types and constants of the paired frame slot manager
// ---------------------------------------------------------------------------
package pfsm_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 3;
  localparam int STAMP_W = 63;
  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_READY = 2'd1,
    ST_USING = 2'd2,
    ST_USED  = 2'd3
  } pfsm_status_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TAKE     = 3'd0,
    MODE_FRAME    = 3'd1,
    MODE_GET_D    = 3'd2,
    MODE_GET_C    = 3'd3,
    MODE_REL_D    = 3'd4,
    MODE_REL_C    = 3'd5,
    MODE_REL_PAIR = 3'd6
  } pfsm_mode_t;

  // search record walking the cell row
  typedef struct packed {
    logic               valid;
    logic               empty_hit;
    logic [SLOT_W-1:0]  empty_idx;
    logic               max_hit;
    logic [STAMP_W-1:0] max_stamp;
    logic [SLOT_W-1:0]  max_idx;
    logic               min_hit;
    logic [STAMP_W-1:0] min_stamp;
    logic [SLOT_W-1:0]  min_idx;
    logic [SLOT_W-1:0]  save_idx;
    pfsm_status_t       save_dst;
    pfsm_status_t       save_cst;
    logic [SLOT_W-1:0]  use_idx;
    pfsm_status_t       use_dst;
    pfsm_status_t       use_cst;
    logic [STAMP_W-1:0] use_stamp;
  } pfsm_probe_t;

  // write broadcast to one cell
  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  idx;
    logic               depth_we;
    pfsm_status_t       depth_st;
    logic               color_we;
    pfsm_status_t       color_st;
    logic               stamp_we;
    logic [STAMP_W-1:0] stamp;
  } pfsm_upd_t;

  typedef struct packed {
    logic               done_res;
    logic [IDX_W-1:0]   slot_index;
    logic               evicted;
    logic               pair_complete;
    logic [STAMP_W-1:0] granted_stamp;
    logic               current_valid;
    logic [1:0]         current_depth_state;
    logic [1:0]         current_color_state;
  } pfsm_res_t;

endpackage

/* hdl/pfsm_in_if.sv */
// ---------------------------------------------------------------------------
// pfsm_in_if
// command channel: valid, ready and one command
// ---------------------------------------------------------------------------
interface pfsm_in_if import pfsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [STAMP_W-1:0] frame_stamp;

  modport source (output valid, output mode, output frame_stamp, input ready);
  modport sink   (input valid, input mode, input frame_stamp, output ready);
endinterface

/* hdl/pfsm_out_if.sv */
// ---------------------------------------------------------------------------
// pfsm_out_if
// result channel: valid, ready and one result
// ---------------------------------------------------------------------------
interface pfsm_out_if import pfsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               done_res;
  logic [IDX_W-1:0]   slot_index;
  logic               evicted;
  logic               pair_complete;
  logic [STAMP_W-1:0] granted_stamp;
  logic               current_valid;
  logic [1:0]         current_depth_state;
  logic [1:0]         current_color_state;

  modport source (output valid, output done_res, output slot_index, output evicted,
                  output pair_complete, output granted_stamp, output current_valid,
                  output current_depth_state, output current_color_state, input ready);
  modport sink   (input valid, input done_res, input slot_index, input evicted,
                  input pair_complete, input granted_stamp, input current_valid,
                  input current_depth_state, input current_color_state, output ready);
endinterface

/* hdl/pfsm_cfg_if.sv */
// ---------------------------------------------------------------------------
// pfsm_cfg_if
// configuration write channel for the capture enable register
// ---------------------------------------------------------------------------
interface pfsm_cfg_if import pfsm_pkg::*; ();
  logic valid;
  logic ready;
  logic capture_enable;

  modport source (output valid, output capture_enable, input ready);
  modport sink   (input valid, input capture_enable, output ready);
endinterface

/* hdl/pfsm_cell.sv */
// ---------------------------------------------------------------------------
// pfsm_cell
// one slot: holds its statuses and stamp, folds itself into the passing
// search record and registers it for the next cell
// ---------------------------------------------------------------------------
module pfsm_cell import pfsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  pfsm_probe_t       probe_in,
  output pfsm_probe_t       probe_out,
  input  pfsm_upd_t         upd
);

  pfsm_status_t       depth_r;
  pfsm_status_t       color_r;
  logic [STAMP_W-1:0] stamp_r;
  pfsm_probe_t        probe_r;
  pfsm_probe_t        probe_nxt;
  logic               full_ready;
  logic               both_empty;
  logic               upd_hit;

  assign full_ready = (depth_r == ST_READY) && (color_r == ST_READY);
  assign both_empty = (depth_r == ST_EMPTY) && (color_r == ST_EMPTY);
  assign upd_hit    = upd.we && (upd.idx == cell_idx);

  always_comb begin
    probe_nxt = probe_in;
    if (both_empty && !probe_in.empty_hit) begin
      probe_nxt.empty_hit = 1'b1;
      probe_nxt.empty_idx = cell_idx;
    end
    if (full_ready && (stamp_r > probe_in.max_stamp)) begin
      probe_nxt.max_hit   = 1'b1;
      probe_nxt.max_stamp = stamp_r;
      probe_nxt.max_idx   = cell_idx;
    end
    if (full_ready && (stamp_r < probe_in.min_stamp)) begin
      probe_nxt.min_hit   = 1'b1;
      probe_nxt.min_stamp = stamp_r;
      probe_nxt.min_idx   = cell_idx;
    end
    if (probe_in.save_idx == cell_idx) begin
      probe_nxt.save_dst = depth_r;
      probe_nxt.save_cst = color_r;
    end
    if (probe_in.use_idx == cell_idx) begin
      probe_nxt.use_dst   = depth_r;
      probe_nxt.use_cst   = color_r;
      probe_nxt.use_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= ST_EMPTY;
      color_r <= ST_EMPTY;
      stamp_r <= '0;
    end else if (upd_hit) begin
      if (upd.depth_we) depth_r <= upd.depth_st;
      if (upd.color_we) color_r <= upd.color_st;
      if (upd.stamp_we) stamp_r <= upd.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

/* hdl/paired_frame_slot_manager.sv */
// ---------------------------------------------------------------------------
// paired_frame_slot_manager
// Slot pool for paired depth and color frames. Commands arrive on in_ch
// (mode, frame_stamp) and each gives exactly one result on out_ch; both use
// a valid/ready transfer. cfg_ch writes capture_enable (always ready); the
// user must write it only while no command is in flight, since the block
// itself does not enforce it. A command walks a row of SLOTS cells, one
// cell per cycle, collecting the first empty slot, the newest and oldest
// fully ready slots and the states of the save and current slots; the
// decision then writes back to at most one cell. A command is taken only
// while idle, so a new one waits until the last has passed the cell row
// and the decision step. The result sits in an output register, so the
// next command is taken while it waits; if the receiver still stalls when
// the following result is due, that command holds in its decision step
// until the register frees. Reset empties all slots, zeroes stamps, drops
// save and current slots and sets capture_enable to one.
// ---------------------------------------------------------------------------
module paired_frame_slot_manager import pfsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pfsm_in_if.sink     in_ch,
  pfsm_out_if.source  out_ch,
  pfsm_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic               cap_en_r;
  logic               launch_r;
  pfsm_mode_t         mode_r;
  logic [STAMP_W-1:0] stamp_r;
  pfsm_probe_t        res_r;
  logic [SLOT_W-1:0]  save_slot_r;
  logic [SLOT_W-1:0]  save_slot_nxt;
  logic               save_valid_r;
  logic               save_valid_nxt;
  logic [SLOT_W-1:0]  use_slot_r;
  logic [SLOT_W-1:0]  use_slot_nxt;
  logic               use_valid_r;
  logic               use_valid_nxt;
  logic               out_valid_r;
  pfsm_res_t          out_r;
  pfsm_res_t          out_nxt;
  pfsm_upd_t          upd;
  pfsm_upd_t          upd_live;
  pfsm_probe_t        chain [SLOTS+1];
  logic               in_xfer;
  logic               commit;
  logic [SLOT_W-1:0]  slot_sel;
  pfsm_status_t       save_d;
  pfsm_status_t       save_c;
  pfsm_status_t       pre_d;
  pfsm_status_t       pre_c;
  pfsm_status_t       half;
  pfsm_status_t       cur_d;
  pfsm_status_t       cur_c;
  logic [STAMP_W-1:0] cur_stamp;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign commit       = (state_r == S_COMMIT) && (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      cap_en_r <= cfg_ch.capture_enable;
    end
  end

  // search record entering the first cell
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = launch_r;
    chain[0].min_stamp = STAMP_MAX;
    chain[0].save_idx  = save_slot_r;
    chain[0].use_idx   = use_slot_r;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pfsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(g)),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1]),
      .upd       (upd_live)
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (chain[SLOTS].valid) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // decision on the collected record
  always_comb begin
    upd            = '0;
    save_slot_nxt  = save_slot_r;
    save_valid_nxt = save_valid_r;
    use_slot_nxt   = use_slot_r;
    use_valid_nxt  = use_valid_r;
    out_nxt        = '0;
    slot_sel       = '0;
    save_d         = res_r.save_dst;
    save_c         = res_r.save_cst;
    pre_d          = res_r.use_dst;
    pre_c          = res_r.use_cst;
    cur_stamp      = res_r.use_stamp;
    half           = ST_EMPTY;
    unique case (mode_r)
      MODE_TAKE: begin
        if (cap_en_r) begin
          save_valid_nxt = 1'b0;
          if (res_r.empty_hit) begin
            save_slot_nxt    = res_r.empty_idx;
            save_valid_nxt   = 1'b1;
            out_nxt.done_res = 1'b1;
            slot_sel         = res_r.empty_idx;
          end else if (res_r.max_hit) begin
            save_slot_nxt    = res_r.max_idx;
            save_valid_nxt   = 1'b1;
            out_nxt.done_res = 1'b1;
            out_nxt.evicted  = 1'b1;
            slot_sel         = res_r.max_idx;
            upd.we           = 1'b1;
            upd.idx          = res_r.max_idx;
            upd.depth_we     = 1'b1;
            upd.depth_st     = ST_EMPTY;
            upd.color_we     = 1'b1;
            upd.color_st     = ST_EMPTY;
          end
        end
      end
      MODE_FRAME: begin
        if (cap_en_r && save_valid_r) begin
          slot_sel = save_slot_r;
          if (save_d == ST_EMPTY) begin
            upd.we           = 1'b1;
            upd.idx          = save_slot_r;
            upd.depth_we     = 1'b1;
            upd.depth_st     = ST_READY;
            upd.stamp_we     = 1'b1;
            upd.stamp        = stamp_r;
            out_nxt.done_res = 1'b1;
            save_d           = ST_READY;
          end else if (save_c == ST_EMPTY) begin
            upd.we           = 1'b1;
            upd.idx          = save_slot_r;
            upd.color_we     = 1'b1;
            upd.color_st     = ST_READY;
            out_nxt.done_res = 1'b1;
            save_c           = ST_READY;
          end
          out_nxt.pair_complete = (save_d != ST_EMPTY) && (save_c != ST_EMPTY);
        end
      end
      MODE_GET_D, MODE_GET_C: begin
        if (!use_valid_r && res_r.min_hit) begin
          use_slot_nxt  = res_r.min_idx;
          use_valid_nxt = 1'b1;
          pre_d         = ST_READY;
          pre_c         = ST_READY;
          cur_stamp     = res_r.min_stamp;
        end
        if (use_valid_nxt) begin
          slot_sel = use_slot_nxt;
          half     = (mode_r == MODE_GET_D) ? pre_d : pre_c;
          if (half == ST_READY) begin
            upd.we                = 1'b1;
            upd.idx               = use_slot_nxt;
            upd.depth_we          = (mode_r == MODE_GET_D);
            upd.depth_st          = ST_USING;
            upd.color_we          = (mode_r == MODE_GET_C);
            upd.color_st          = ST_USING;
            out_nxt.done_res      = 1'b1;
            out_nxt.granted_stamp = cur_stamp;
          end
        end
      end
      MODE_REL_D, MODE_REL_C: begin
        if (use_valid_r) begin
          slot_sel         = use_slot_r;
          upd.we           = 1'b1;
          upd.idx          = use_slot_r;
          upd.depth_we     = (mode_r == MODE_REL_D);
          upd.depth_st     = ST_USED;
          upd.color_we     = (mode_r == MODE_REL_C);
          upd.color_st     = ST_USED;
          out_nxt.done_res = 1'b1;
        end
      end
      MODE_REL_PAIR: begin
        if (use_valid_r) begin
          slot_sel = use_slot_r;
          if ((pre_d == ST_USED) && (pre_c == ST_USED)) begin
            upd.we           = 1'b1;
            upd.idx          = use_slot_r;
            upd.depth_we     = 1'b1;
            upd.depth_st     = ST_EMPTY;
            upd.color_we     = 1'b1;
            upd.color_st     = ST_EMPTY;
            use_valid_nxt    = 1'b0;
            out_nxt.done_res = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // current slot states after the write
    cur_d = pre_d;
    cur_c = pre_c;
    if (upd.we && (upd.idx == use_slot_nxt)) begin
      if (upd.depth_we) cur_d = upd.depth_st;
      if (upd.color_we) cur_c = upd.color_st;
    end
    out_nxt.slot_index    = IDX_W'(slot_sel);
    out_nxt.current_valid = use_valid_nxt;
    if (use_valid_nxt) begin
      out_nxt.current_depth_state = cur_d;
      out_nxt.current_color_state = cur_c;
    end
  end

  always_comb begin
    upd_live    = upd;
    upd_live.we = upd.we && commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      launch_r     <= 1'b0;
      save_slot_r  <= '0;
      save_valid_r <= 1'b0;
      use_slot_r   <= '0;
      use_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= in_xfer;
      if (commit) begin
        save_slot_r  <= save_slot_nxt;
        save_valid_r <= save_valid_nxt;
        use_slot_r   <= use_slot_nxt;
        use_valid_r  <= use_valid_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r  <= pfsm_mode_t'(in_ch.mode);
      stamp_r <= in_ch.frame_stamp;
    end
    if ((state_r == S_SCAN) && chain[SLOTS].valid) begin
      res_r <= chain[SLOTS];
    end
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.done_res            = out_r.done_res;
  assign out_ch.slot_index          = out_r.slot_index;
  assign out_ch.evicted             = out_r.evicted;
  assign out_ch.pair_complete       = out_r.pair_complete;
  assign out_ch.granted_stamp       = out_r.granted_stamp;
  assign out_ch.current_valid       = out_r.current_valid;
  assign out_ch.current_depth_state = out_r.current_depth_state;
  assign out_ch.current_color_state = out_r.current_color_state;

endmodule

/* hdl/pfsm_checker.sv */
// ---------------------------------------------------------------------------
// pfsm_checker
// port-level checks on the result channel, bound to the top level
// ---------------------------------------------------------------------------
`include "paired_frame_slot_manager_defines.svh"

module pfsm_checker import pfsm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               done_res,
  input logic [IDX_W-1:0]   slot_index,
  input logic               evicted,
  input logic               pair_complete,
  input logic [STAMP_W-1:0] granted_stamp,
  input logic               current_valid,
  input logic [1:0]         current_depth_state,
  input logic [1:0]         current_color_state
);

  `PFSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(done_res) && $stable(slot_index) && $stable(evicted) && $stable(pair_complete) && $stable(granted_stamp) && $stable(current_valid) && $stable(current_depth_state) && $stable(current_color_state), "result changed while stalled")
  `PFSM_ASSERT_NOW(a_evict_done, out_valid && evicted, done_res && !pair_complete, "eviction without a taken slot")
  `PFSM_ASSERT_NOW(a_no_current, out_valid && !current_valid, current_depth_state == ST_EMPTY && current_color_state == ST_EMPTY, "states shown with no current slot")
  `PFSM_ASSERT_NOW(a_grant_done, out_valid && !done_res, granted_stamp == '0 && !evicted, "stamp granted on a failed command")

endmodule

bind paired_frame_slot_manager pfsm_checker u_pfsm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .done_res            (out_ch.done_res),
  .slot_index          (out_ch.slot_index),
  .evicted             (out_ch.evicted),
  .pair_complete       (out_ch.pair_complete),
  .granted_stamp       (out_ch.granted_stamp),
  .current_valid       (out_ch.current_valid),
  .current_depth_state (out_ch.current_depth_state),
  .current_color_state (out_ch.current_color_state)
);

/* sim/slot_pool_tracker_pkg.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// slot pool tracker
// Mirrors the slot pool of the paired frame slot manager: statuses, stamps,
// save and current slots and capture enable. Each command transfer queues
// one predicted result, and each result transfer is checked against the
// oldest entry, field by field.
// ---------------------------------------------------------------------------
package slot_pool_tracker_pkg;
  import pfsm_pkg::*;

  class slot_pool_tracker;
    pfsm_status_t       depth_st [SLOTS];
    pfsm_status_t       color_st [SLOTS];
    logic [STAMP_W-1:0] stamp_mem [SLOTS];
    logic [SLOT_W-1:0]  cur_slot;
    logic               cur_held;
    logic [SLOT_W-1:0]  save_idx;
    logic               save_held;
    logic               capture_on;
    pfsm_res_t          awaited [$];
    int                 fail_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        depth_st[i]  = ST_EMPTY;
        color_st[i]  = ST_EMPTY;
        stamp_mem[i] = '0;
      end
      cur_slot   = '0;
      cur_held   = 1'b0;
      save_idx   = '0;
      save_held  = 1'b0;
      capture_on = 1'b1;
      fail_count = 0;
    endfunction

    function void set_capture(logic v);
      capture_on = v;
    endfunction

    function int awaited_count();
      return awaited.size();
    endfunction

    function bit both_ready(int i);
      return depth_st[i] == ST_READY && color_st[i] == ST_READY;
    endfunction

    // oldest fully ready pair, earliest index on ties
    function void choose_current();
      logic [STAMP_W-1:0] best;
      best = STAMP_MAX;
      if (cur_held) return;
      for (int i = 0; i < SLOTS; i++) begin
        if (both_ready(i) && stamp_mem[i] < best) begin
          best     = stamp_mem[i];
          cur_slot = SLOT_W'(i);
          cur_held = 1'b1;
        end
      end
    endfunction

    function logic note_command(logic [MODE_W-1:0] m, logic [STAMP_W-1:0] s);
      pfsm_res_t          r;
      logic [STAMP_W-1:0] best;
      r = '0;
      case (m)
        MODE_TAKE: begin
          if (capture_on) begin
            save_held = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
              if (!save_held && depth_st[i] == ST_EMPTY && color_st[i] == ST_EMPTY) begin
                save_idx  = SLOT_W'(i);
                save_held = 1'b1;
              end
            end
            if (!save_held) begin
              // evict the newest ready pair
              best = '0;
              for (int i = 0; i < SLOTS; i++) begin
                if (both_ready(i) && stamp_mem[i] > best) begin
                  best      = stamp_mem[i];
                  save_idx  = SLOT_W'(i);
                  save_held = 1'b1;
                end
              end
              if (save_held) begin
                depth_st[save_idx] = ST_EMPTY;
                color_st[save_idx] = ST_EMPTY;
                r.evicted = 1'b1;
              end
            end
            if (save_held) begin
              r.done_res   = 1'b1;
              r.slot_index = save_idx;
            end
          end
        end
        MODE_FRAME: begin
          if (capture_on && save_held) begin
            r.slot_index = save_idx;
            if (depth_st[save_idx] == ST_EMPTY) begin
              depth_st[save_idx]  = ST_READY;
              stamp_mem[save_idx] = s;
              r.done_res = 1'b1;
            end else if (color_st[save_idx] == ST_EMPTY) begin
              color_st[save_idx] = ST_READY;
              r.done_res = 1'b1;
            end
            r.pair_complete = depth_st[save_idx] != ST_EMPTY && color_st[save_idx] != ST_EMPTY;
          end
        end
        MODE_GET_D, MODE_GET_C: begin
          choose_current();
          if (cur_held) begin
            r.slot_index = cur_slot;
            if (m == MODE_GET_D && depth_st[cur_slot] == ST_READY) begin
              depth_st[cur_slot] = ST_USING;
              r.done_res      = 1'b1;
              r.granted_stamp = stamp_mem[cur_slot];
            end else if (m == MODE_GET_C && color_st[cur_slot] == ST_READY) begin
              color_st[cur_slot] = ST_USING;
              r.done_res      = 1'b1;
              r.granted_stamp = stamp_mem[cur_slot];
            end
          end
        end
        MODE_REL_D, MODE_REL_C: begin
          if (cur_held) begin
            r.slot_index = cur_slot;
            if (m == MODE_REL_D) depth_st[cur_slot] = ST_USED;
            else color_st[cur_slot] = ST_USED;
            r.done_res = 1'b1;
          end
        end
        MODE_REL_PAIR: begin
          if (cur_held) begin
            r.slot_index = cur_slot;
            if (depth_st[cur_slot] == ST_USED && color_st[cur_slot] == ST_USED) begin
              depth_st[cur_slot] = ST_EMPTY;
              color_st[cur_slot] = ST_EMPTY;
              cur_held   = 1'b0;
              r.done_res = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.current_valid       = cur_held;
      r.current_depth_state = cur_held ? depth_st[cur_slot] : ST_EMPTY;
      r.current_color_state = cur_held ? color_st[cur_slot] : ST_EMPTY;
      awaited.push_back(r);
      return r.done_res;
    endfunction

    function void compare_field(string name, logic [STAMP_W-1:0] want,
                                logic [STAMP_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(pfsm_res_t got);
      pfsm_res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0h", $time, got);
        fail_count++;
        return;
      end
      want = awaited.pop_front();
      compare_field("done_res", STAMP_W'(want.done_res), STAMP_W'(got.done_res));
      compare_field("slot_index", STAMP_W'(want.slot_index), STAMP_W'(got.slot_index));
      compare_field("evicted", STAMP_W'(want.evicted), STAMP_W'(got.evicted));
      compare_field("pair_complete", STAMP_W'(want.pair_complete),
                    STAMP_W'(got.pair_complete));
      compare_field("granted_stamp", want.granted_stamp, got.granted_stamp);
      compare_field("current_valid", STAMP_W'(want.current_valid),
                    STAMP_W'(got.current_valid));
      compare_field("current_depth_state", STAMP_W'(want.current_depth_state),
                    STAMP_W'(got.current_depth_state));
      compare_field("current_color_state", STAMP_W'(want.current_color_state),
                    STAMP_W'(got.current_color_state));
    endfunction
  endclass

endpackage

/* sim/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// paired frame slot manager testbench
// Drives commands and capture enable writes, predicts every result with a
// slot pool tracker and checks each result transfer. A directed opening is
// followed by random producer and consumer sequences plus noise, under
// three idling patterns and both capture enable settings.
// ---------------------------------------------------------------------------
module tb;
  import pfsm_pkg::*;
  import slot_pool_tracker_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4 * (SLOTS + 2);

  logic clk;
  logic rst_n;

  pfsm_in_if  in_ch ();
  pfsm_out_if out_ch ();
  pfsm_cfg_if cfg_ch ();

  slot_pool_tracker tracker;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int sent_items;
  int acted_items;

  paired_frame_slot_manager i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    int          pick;
    pick = $urandom_range(99);
    w    = {$urandom, $urandom};
    if (pick < 10) return '0;
    if (pick < 20) return STAMP_MAX;
    if (pick < 50) return STAMP_W'($urandom_range(15));
    return w[STAMP_W-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_command(input logic [MODE_W-1:0] m, input logic [STAMP_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.frame_stamp <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tracker.note_command(m, s)) acted_items++;
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_capture(input logic v);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.capture_enable <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.set_capture(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.awaited_count() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    push_command(MODE_REL_D, '0);
    push_command(MODE_REL_PAIR, '0);
    push_command(MODE_GET_D, '0);
    push_command(MODE_UNUSED, STAMP_MAX);
    push_command(MODE_FRAME, 63'd9);
    push_command(MODE_TAKE, '0);
    push_command(MODE_FRAME, STAMP_MAX);
    push_command(MODE_FRAME, rand_stamp());
    push_command(MODE_FRAME, rand_stamp());
    push_command(MODE_TAKE, '0);
    push_command(MODE_FRAME, '0);
    push_command(MODE_FRAME, rand_stamp());
    push_command(MODE_TAKE, '0);
    push_command(MODE_FRAME, 63'd5);
    push_command(MODE_FRAME, rand_stamp());
    push_command(MODE_GET_C, '0);
    push_command(MODE_GET_C, '0);
    push_command(MODE_GET_D, '0);
    push_command(MODE_REL_PAIR, '0);
    push_command(MODE_REL_D, '0);
    push_command(MODE_REL_C, '0);
    push_command(MODE_REL_PAIR, '0);
    push_command(MODE_GET_D, '0);
  endtask

  task automatic run_random(input int target, input int cap);
    logic [MODE_W-1:0] seq [5];
    logic [MODE_W-1:0] tmp;
    int                r;
    int                k;
    acted_items = 0;
    sent_items  = 0;
    while (acted_items < target && sent_items < cap) begin
      r = $urandom_range(99);
      if (r < 40) begin
        push_command(MODE_TAKE, rand_stamp());
        push_command(MODE_FRAME, rand_stamp());
        if ($urandom_range(9) != 0) push_command(MODE_FRAME, rand_stamp());
      end else if (r < 80) begin
        seq[0] = MODE_GET_D;
        seq[1] = MODE_GET_C;
        seq[2] = MODE_REL_D;
        seq[3] = MODE_REL_C;
        seq[4] = MODE_REL_PAIR;
        if ($urandom_range(4) == 0) begin
          k        = $urandom_range(3);
          tmp      = seq[k];
          seq[k]   = seq[k+1];
          seq[k+1] = tmp;
        end
        for (int i = 0; i < 5; i++) begin
          if ($urandom_range(9) != 0) push_command(seq[i], rand_stamp());
        end
      end else begin
        push_command(MODE_W'($urandom_range(7)), rand_stamp());
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    pfsm_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.done_res            = out_ch.done_res;
      got.slot_index          = out_ch.slot_index;
      got.evicted             = out_ch.evicted;
      got.pair_complete       = out_ch.pair_complete;
      got.granted_stamp       = out_ch.granted_stamp;
      got.current_valid       = out_ch.current_valid;
      got.current_depth_state = out_ch.current_depth_state;
      got.current_color_state = out_ch.current_color_state;
      tracker.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    tracker               = new();
    quiet_cycles          = 0;
    send_idle_pct         = 36;
    recv_idle_pct         = 65;
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_TAKE;
    in_ch.frame_stamp     = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.capture_enable = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    write_capture(1'b1);
    run_directed();
    run_random(230, 240);
    wait_idle();
    write_capture(1'b0);
    run_random(20, 30);
    wait_idle();

    send_idle_pct = 65;
    recv_idle_pct = 36;
    write_capture(1'b1);
    run_random(230, 240);
    wait_idle();
    write_capture(1'b0);
    run_random(20, 30);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capture(1'b1);
    run_random(230, 240);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.fail_count == 0 && tracker.awaited_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
